[rtl/page_framebuffer_refresh_assert.svh]
// Assertion macros shared by the checker of the frame store.
`ifndef PAGE_FRAMEBUFFER_REFRESH_ASSERT_SVH
`define PAGE_FRAMEBUFFER_REFRESH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/pfr_pkg.sv]
`default_nettype none
package pfr_pkg;

   localparam int COLUMNS     = 128;
   localparam int PAGES       = 8;
   localparam int STORE_BYTES = COLUMNS * PAGES;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int CNT_W       = $clog2(STORE_BYTES + 1);
   localparam int PAGE_W      = (PAGES > 1) ? $clog2(PAGES) : 1;
   localparam int DATA_START  = 3;
   localparam int POS_W       = $clog2(COLUMNS + DATA_START);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CMD_PAGE_BASE       = 8'hB0;
   localparam logic [7:0] CMD_HIGH_COLUMN     = 8'h10;
   localparam logic [3:0] COLUMN_OFFSET_RESET = 4'h2;

   localparam logic [2:0] REQ_DRAW    = 3'd0;
   localparam logic [2:0] REQ_CLEAR   = 3'd1;
   localparam logic [2:0] REQ_SAVE    = 3'd2;
   localparam logic [2:0] REQ_RESTORE = 3'd3;
   localparam logic [2:0] REQ_START   = 3'd4;
   localparam logic [2:0] REQ_TICK    = 3'd5;

   typedef enum logic [2:0] {
      OP_DRAW,
      OP_CLEAR,
      OP_SAVE,
      OP_RESTORE,
      OP_START,
      OP_TICK
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [ADDR_W-1:0]   addr;
      logic [2:0]          bit_sel;
      logic                on;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_out_type;

   typedef struct packed {
      logic init_busy;
   } back_status_type;

endpackage
`default_nettype wire

[rtl/page_framebuffer_refresh.sv]
// Monochrome page-organised frame store with a panel refresh streamer.
// Request words on req_* are taken when req_valid is high and req_stall low;
// all but off-panel draws and unknown types pass into a two-word queue and
// are carried out in order behind it. A draw reads its byte as it leaves
// the queue head and writes it back in ST_DRAW_WR; a tick loads a command
// byte straight into the output register, a data byte after a store read.
// A start restarts the streamer at page 0; clear, save and restore sweep the whole store.
// Requests that cause no word leave no trace on rsp_*.
// A refresh word is held on rsp_* in an output register until it is taken
// without rsp_stall.
// While rsp_stall holds a word, the next tick of an active refresh waits at
// the queue head and the queue keeps taking requests until it is full.
// After a synchronous reset the frame store is zeroed by a clearing pass,
// during which req_stall stays high; csr writes to the column offset (reset
// value 2) are taken whenever reset is low.
`default_nettype none
module page_framebuffer_refresh (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [2:0] req_type,
   input  wire logic [7:0] req_pixel_x,
   input  wire logic [7:0] req_pixel_y,
   input  wire logic       req_pixel_on,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_is_data,
   output logic            rsp_frame_last,
   input  wire logic       csr_write_enable,
   input  wire logic [3:0] csr_write_data
);
   import pfr_pkg::*;

   queue_out_type   queue_out;
   logic            queue_pop;
   back_status_type status;

   pfr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_type     (req_type),
      .req_pixel_x  (req_pixel_x),
      .req_pixel_y  (req_pixel_y),
      .req_pixel_on (req_pixel_on),
      .status       (status),
      .queue_out    (queue_out),
      .queue_pop    (queue_pop)
   );

   pfr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .queue_out        (queue_out),
      .queue_pop        (queue_pop),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_is_data      (rsp_is_data),
      .rsp_frame_last   (rsp_frame_last)
   );

endmodule
`default_nettype wire

[rtl/pfr_front.sv]
`default_nettype none
module pfr_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [2:0]               req_type,
   input  wire logic [7:0]               req_pixel_x,
   input  wire logic [7:0]               req_pixel_y,
   input  wire logic                     req_pixel_on,
   input  wire pfr_pkg::back_status_type status,
   output pfr_pkg::queue_out_type        queue_out,
   input  wire logic                     queue_pop
);
   import pfr_pkg::*;

   cmd_type             q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   cmd_type             cmd;
   logic                keep;
   logic                in_range;
   logic [PAGE_W-1:0]   page;
   logic                push;
   logic                full;

   always_comb begin
      in_range    = (req_pixel_x <= 8'(COLUMNS - 1)) && (req_pixel_y <= 8'(8 * PAGES - 1));
      page        = PAGE_W'(req_pixel_y >> 3);
      cmd.addr    = ADDR_W'(ADDR_W'(page) * ADDR_W'(COLUMNS) + ADDR_W'(req_pixel_x));
      cmd.bit_sel = req_pixel_y[2:0];
      cmd.on      = req_pixel_on;
      cmd.op      = OP_TICK;
      keep        = 1'b1;
      case (req_type)
         REQ_DRAW: begin
            cmd.op = OP_DRAW;
            keep   = in_range;
         end
         REQ_CLEAR:   cmd.op = OP_CLEAR;
         REQ_SAVE:    cmd.op = OP_SAVE;
         REQ_RESTORE: cmd.op = OP_RESTORE;
         REQ_START:   cmd.op = OP_START;
         REQ_TICK:    cmd.op = OP_TICK;
         default:     keep   = 1'b0;
      endcase
   end

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign req_stall = reset || status.init_busy || full;
   assign push      = req_valid && !req_stall && keep;

   assign queue_out.valid = (count_ff != '0);
   assign queue_out.cmd   = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (queue_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !queue_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && queue_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

[rtl/pfr_back.sv]
`default_nettype none
module pfr_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_enable,
   input  wire logic [3:0]             csr_write_data,
   input  wire pfr_pkg::queue_out_type queue_out,
   output logic                        queue_pop,
   output pfr_pkg::back_status_type    status,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_is_data,
   output logic                        rsp_frame_last
);
   import pfr_pkg::*;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_DRAW_WR,
      ST_CLEAR,
      ST_SAVE,
      ST_RESTORE,
      ST_TICK_RD
   } state_type;

   logic [7:0]          frame_mem  [STORE_BYTES];
   logic [7:0]          backup_mem [STORE_BYTES];
   logic [7:0]          frame_rd_ff;
   logic [7:0]          backup_rd_ff;

   logic                frame_we;
   logic [ADDR_W-1:0]   frame_waddr;
   logic [7:0]          frame_wdata;
   logic [ADDR_W-1:0]   frame_raddr;
   logic                backup_we;
   logic [ADDR_W-1:0]   backup_waddr;
   logic [ADDR_W-1:0]   backup_raddr;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                active_ff, active_in;
   logic [PAGE_W-1:0]   page_ff, page_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [3:0]          col_offset_ff, col_offset_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_byte_ff, rsp_byte_in;
   logic                rsp_is_data_ff, rsp_is_data_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [ADDR_W-1:0]   draw_addr_ff, draw_addr_in;
   logic [7:0]          draw_mask_ff, draw_mask_in;
   logic                draw_on_ff, draw_on_in;
   logic                tick_last_ff, tick_last_in;

   cmd_type             cmd;
   logic                rsp_free;
   logic                page_end;
   logic                frame_end;

   assign cmd       = queue_out.cmd;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign page_end  = (pos_ff >= POS_W'(COLUMNS + DATA_START - 1));
   assign frame_end = page_end && ((32'(page_ff) + 1) >= PAGES);

   assign status.init_busy = (state_ff == ST_INIT);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = rsp_byte_ff;
   assign rsp_is_data      = rsp_is_data_ff;
   assign rsp_frame_last   = rsp_last_ff;

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      active_in      = active_ff;
      page_in        = page_ff;
      pos_in         = pos_ff;
      col_offset_in  = csr_write_enable ? csr_write_data : col_offset_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_byte_in    = rsp_byte_ff;
      rsp_is_data_in = rsp_is_data_ff;
      rsp_last_in    = rsp_last_ff;
      draw_addr_in   = draw_addr_ff;
      draw_mask_in   = draw_mask_ff;
      draw_on_in     = draw_on_ff;
      tick_last_in   = tick_last_ff;
      queue_pop      = 1'b0;
      frame_we       = 1'b0;
      frame_waddr    = ADDR_W'(cnt_ff);
      frame_wdata    = '0;
      frame_raddr    = ADDR_W'(cnt_ff);
      backup_we      = 1'b0;
      backup_waddr   = ADDR_W'(cnt_ff - 1'b1);
      backup_raddr   = ADDR_W'(cnt_ff);

      case (state_ff)
         ST_INIT, ST_CLEAR: begin
            frame_we = 1'b1;
            if (cnt_ff == CNT_W'(STORE_BYTES - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SAVE: begin
            backup_we = (cnt_ff != '0);
            if (cnt_ff == CNT_W'(STORE_BYTES)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_RESTORE: begin
            frame_we    = (cnt_ff != '0);
            frame_waddr = ADDR_W'(cnt_ff - 1'b1);
            frame_wdata = backup_rd_ff;
            if (cnt_ff == CNT_W'(STORE_BYTES)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DRAW_WR: begin
            frame_we    = 1'b1;
            frame_waddr = draw_addr_ff;
            frame_wdata = draw_on_ff ? (frame_rd_ff | draw_mask_ff)
                                     : (frame_rd_ff & ~draw_mask_ff);
            state_in    = ST_IDLE;
         end
         ST_TICK_RD: begin
            rsp_valid_in   = 1'b1;
            rsp_byte_in    = frame_rd_ff;
            rsp_is_data_in = 1'b1;
            rsp_last_in    = tick_last_ff;
            state_in       = ST_IDLE;
         end
         ST_IDLE: begin
            cnt_in = '0;
            if (queue_out.valid) begin
               case (cmd.op)
                  OP_DRAW: begin
                     queue_pop    = 1'b1;
                     frame_raddr  = cmd.addr;
                     draw_addr_in = cmd.addr;
                     draw_mask_in = 8'b1 << cmd.bit_sel;
                     draw_on_in   = cmd.on;
                     state_in     = ST_DRAW_WR;
                  end
                  OP_CLEAR: begin
                     queue_pop = 1'b1;
                     state_in  = ST_CLEAR;
                  end
                  OP_SAVE: begin
                     queue_pop = 1'b1;
                     state_in  = ST_SAVE;
                  end
                  OP_RESTORE: begin
                     queue_pop = 1'b1;
                     state_in  = ST_RESTORE;
                  end
                  OP_START: begin
                     queue_pop = 1'b1;
                     active_in = 1'b1;
                     page_in   = '0;
                     pos_in    = '0;
                  end
                  OP_TICK: begin
                     if (!active_ff) begin
                        queue_pop = 1'b1;
                     end else if (rsp_free) begin
                        queue_pop = 1'b1;
                        if (pos_ff < POS_W'(DATA_START)) begin
                           rsp_valid_in   = 1'b1;
                           rsp_is_data_in = 1'b0;
                           rsp_last_in    = 1'b0;
                           if (pos_ff == '0) begin
                              rsp_byte_in = CMD_PAGE_BASE + 8'(page_ff);
                           end else if (pos_ff == POS_W'(1)) begin
                              rsp_byte_in = {4'h0, col_offset_ff};
                           end else begin
                              rsp_byte_in = CMD_HIGH_COLUMN;
                           end
                        end else begin
                           frame_raddr  = ADDR_W'(ADDR_W'(page_ff) * ADDR_W'(COLUMNS)
                                          + ADDR_W'(pos_ff) - ADDR_W'(DATA_START));
                           tick_last_in = frame_end;
                           state_in     = ST_TICK_RD;
                        end
                        if (page_end) begin
                           pos_in = '0;
                           if (frame_end) begin
                              active_in = 1'b0;
                              page_in   = '0;
                           end else begin
                              page_in = page_ff + 1'b1;
                           end
                        end else begin
                           pos_in = pos_ff + 1'b1;
                        end
                     end
                  end
                  default: queue_pop = 1'b1;
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (frame_we) begin
         frame_mem[frame_waddr] <= frame_wdata;
      end
      frame_rd_ff <= frame_mem[frame_raddr];
   end

   always_ff @(posedge clock) begin
      if (backup_we) begin
         backup_mem[backup_waddr] <= frame_rd_ff;
      end
      backup_rd_ff <= backup_mem[backup_raddr];
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff    <= rsp_byte_in;
      rsp_is_data_ff <= rsp_is_data_in;
      rsp_last_ff    <= rsp_last_in;
      draw_addr_ff   <= draw_addr_in;
      draw_mask_ff   <= draw_mask_in;
      draw_on_ff     <= draw_on_in;
      tick_last_ff   <= tick_last_in;
      if (reset) begin
         state_ff      <= ST_INIT;
         cnt_ff        <= '0;
         active_ff     <= 1'b0;
         page_ff       <= '0;
         pos_ff        <= '0;
         col_offset_ff <= COLUMN_OFFSET_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         active_ff     <= active_in;
         page_ff       <= page_in;
         pos_ff        <= pos_in;
         col_offset_ff <= col_offset_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

[rtl/pfr_checker.sv]
`default_nettype none
`include "page_framebuffer_refresh_assert.svh"
module pfr_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_is_data,
   input wire logic       rsp_frame_last
);

   `PFR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp word dropped")
   `PFR_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_out_byte) && $stable(rsp_is_data) && $stable(rsp_frame_last), "rsp payload changed")
   `PFR_ASSERT_SAME(a_last_is_data, clock, reset, rsp_valid && rsp_frame_last, rsp_is_data, "last flag on a command byte")
   `PFR_ASSERT_NEXT(a_reset_stall, clock, 1'b0, reset, req_stall, "request taken during clearing pass")

endmodule

bind page_framebuffer_refresh pfr_checker u_checker (.*);
`default_nettype wire

[dv/page_framebuffer_refresh_tb.sv]
module page_framebuffer_refresh_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pfr_pkg::*;

   localparam logic [2:0] REQ_SPARE_SIX   = 3'd6;
   localparam logic [2:0] REQ_SPARE_SEVEN = 3'd7;
   localparam int ROWS            = 8 * PAGES;
   localparam int RANDOM_REQUESTS = 400;
   localparam int HOLD_CYCLES     = 240;
   localparam int SETTLE_CYCLES   = 3200;
   localparam int STALL_LIMIT     = 20000;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] x;
      logic [7:0] y;
      logic       on;
   } request_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_data;
      logic       frame_last;
   } panel_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_type = REQ_TICK;
   logic [7:0] req_pixel_x = 8'h00;
   logic [7:0] req_pixel_y = 8'h00;
   logic       req_pixel_on = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_is_data;
   logic       rsp_frame_last;
   logic       csr_write_enable = 1'b0;
   logic [3:0] csr_write_data = 4'h0;

   page_framebuffer_refresh uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_pixel_x      (req_pixel_x),
      .req_pixel_y      (req_pixel_y),
      .req_pixel_on     (req_pixel_on),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_is_data      (rsp_is_data),
      .rsp_frame_last   (rsp_frame_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   logic [7:0]        frame_copy [STORE_BYTES];
   logic [7:0]        backup_copy [STORE_BYTES];
   logic              streaming = 1'b0;
   logic [PAGE_W-1:0] scan_page = '0;
   logic [POS_W-1:0]  scan_pos = '0;
   logic [3:0]        offset_copy = COLUMN_OFFSET_RESET;

   request_word_type request_backlog [$];
   panel_word_type   panel_words_due [$];
   logic             backup_written = 1'b0;
   int               requests_queued = 0;
   int               requests_taken = 0;
   int               sweeps_queued = 0;
   int               panel_words_checked = 0;
   int               frames_finished = 0;
   int               mismatches = 0;

   // Applies one accepted request word to the local copy of the store and the
   // refresh streamer, and records the panel word that a tick gives out.
   task automatic apply_request(input request_word_type req);
      panel_word_type word;
      int             slot;
      case (req.kind)
         REQ_DRAW: begin
            if (req.x < COLUMNS && req.y < ROWS) begin
               slot = int'(req.y[7:3]) * COLUMNS + int'(req.x);
               frame_copy[slot][req.y[2:0]] = req.on;
            end
         end
         REQ_CLEAR: begin
            for (int i = 0; i < STORE_BYTES; i++) frame_copy[i] = 8'h00;
         end
         REQ_SAVE: begin
            for (int i = 0; i < STORE_BYTES; i++) backup_copy[i] = frame_copy[i];
         end
         REQ_RESTORE: begin
            for (int i = 0; i < STORE_BYTES; i++) frame_copy[i] = backup_copy[i];
         end
         REQ_START: begin
            streaming = 1'b1;
            scan_page = '0;
            scan_pos = '0;
         end
         REQ_TICK: begin
            if (streaming) begin
               word.is_data = 1'b0;
               word.frame_last = 1'b0;
               if (scan_pos == 0) begin
                  word.out_byte = CMD_PAGE_BASE + scan_page;
               end else if (scan_pos == 1) begin
                  word.out_byte = {4'h0, offset_copy};
               end else if (scan_pos == 2) begin
                  word.out_byte = CMD_HIGH_COLUMN;
               end else begin
                  slot = int'(scan_page) * COLUMNS + int'(scan_pos) - DATA_START;
                  word.out_byte = frame_copy[slot];
                  word.is_data = 1'b1;
               end
               if (scan_pos == COLUMNS + DATA_START - 1) begin
                  scan_pos = '0;
                  if (scan_page == PAGES - 1) begin
                     word.frame_last = 1'b1;
                     streaming = 1'b0;
                     scan_page = '0;
                  end else begin
                     scan_page = scan_page + 1'b1;
                  end
               end else begin
                  scan_pos = scan_pos + 1'b1;
               end
               panel_words_due.push_back(word);
            end
         end
         default: begin
         end
      endcase
   endtask

   // A restore is only ever queued once a save has gone before it.
   task automatic queue_request(input logic [2:0] kind, input logic [7:0] x,
                                input logic [7:0] y, input logic on);
      request_word_type req;
      if (kind == REQ_RESTORE && !backup_written) kind = REQ_SAVE;
      if (kind == REQ_SAVE) backup_written = 1'b1;
      if (kind == REQ_CLEAR || kind == REQ_SAVE || kind == REQ_RESTORE) sweeps_queued++;
      req.kind = kind;
      req.x = x;
      req.y = y;
      req.on = on;
      request_backlog.push_back(req);
      requests_queued++;
   endtask

   task automatic queue_op(input logic [2:0] kind);
      queue_request(kind, 8'($urandom), 8'($urandom), 1'($urandom));
   endtask

   task automatic queue_random_draw();
      logic [7:0] x;
      logic [7:0] y;
      x = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, COLUMNS - 1))
                                         : 8'($urandom_range(0, 255));
      y = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, ROWS - 1))
                                         : 8'($urandom_range(0, 255));
      queue_request(REQ_DRAW, x, y, 1'($urandom));
   endtask

   task automatic queue_side_request();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 80) queue_random_draw();
      else if (pick < 84) queue_op(REQ_CLEAR);
      else if (pick < 88) queue_op(REQ_SAVE);
      else if (pick < 91) queue_op(REQ_RESTORE);
      else if (pick < 95) queue_op(pick[0] ? REQ_SPARE_SIX : REQ_SPARE_SEVEN);
      else queue_op(REQ_TICK);
   endtask

   task automatic queue_refresh(input int ticks, input int side_percent);
      queue_op(REQ_START);
      for (int i = 0; i < ticks; i++) begin
         if ($urandom_range(0, 99) < side_percent) queue_side_request();
         queue_op(REQ_TICK);
      end
   endtask

   task automatic queue_random_phase(input int budget);
      int first;
      first = requests_queued;
      while (requests_queued - first < budget) begin
         if ($urandom_range(0, 99) < 55) queue_refresh($urandom_range(0, 40), 15);
         else repeat ($urandom_range(1, 10)) queue_side_request();
      end
   endtask

   task automatic wait_until_drained();
      do @(negedge clock);
      while (requests_taken != requests_queued || panel_words_due.size() != 0);
   endtask

   // Requests that give no word may still be sweeping the store, so the
   // write waits out the longest backlog the input queue can hold.
   task automatic set_column_offset(input logic [3:0] value);
      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      offset_copy = value;
      @(negedge clock);
   endtask

   always @(posedge clock) begin : sender
      int               send_wait;
      logic             send_burst;
      request_word_type taken;
      request_word_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
         send_burst = 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            taken.kind = req_type;
            taken.x = req_pixel_x;
            taken.y = req_pixel_y;
            taken.on = req_pixel_on;
            apply_request(taken);
            requests_taken++;
         end
         if (!(req_valid && req_stall)) begin
            if (send_wait != 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (request_backlog.size() != 0) begin
               next_req = request_backlog.pop_front();
               req_valid <= 1'b1;
               req_type <= next_req.kind;
               req_pixel_x <= next_req.x;
               req_pixel_y <= next_req.y;
               req_pixel_on <= next_req.on;
               if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
               send_wait = send_burst ? 0 : $urandom_range(0, 4);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : receiver
      int             recv_wait;
      int             wait_next;
      logic           recv_burst;
      panel_word_type due;
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_wait = 0;
         recv_burst = 1'b0;
      end else begin
         wait_next = recv_wait;
         if (rsp_valid && !rsp_stall) begin
            if (panel_words_due.size() == 0) begin
               $display("%0t ns: unexpected word, out_byte %h is_data %b frame_last %b",
                        $time, rsp_out_byte, rsp_is_data, rsp_frame_last);
               mismatches++;
            end else begin
               due = panel_words_due.pop_front();
               if (rsp_out_byte !== due.out_byte) begin
                  $display("%0t ns: out_byte expected %h, got %h",
                           $time, due.out_byte, rsp_out_byte);
                  mismatches++;
               end
               if (rsp_is_data !== due.is_data) begin
                  $display("%0t ns: is_data expected %b, got %b",
                           $time, due.is_data, rsp_is_data);
                  mismatches++;
               end
               if (rsp_frame_last !== due.frame_last) begin
                  $display("%0t ns: frame_last expected %b, got %b",
                           $time, due.frame_last, rsp_frame_last);
                  mismatches++;
               end
               if (due.frame_last) frames_finished++;
               panel_words_checked++;
            end
            if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
            wait_next = recv_burst ? 0 : $urandom_range(0, 4);
            // A long hold lets the input queue fill so that req_stall rises.
            if (panel_words_checked == 20 || panel_words_checked == 100)
               wait_next = HOLD_CYCLES;
         end else if (wait_next != 0) begin
            wait_next--;
         end
         recv_wait = wait_next;
         rsp_stall <= (wait_next != 0);
      end
   end

   always @(posedge clock) begin : watchdog
      int idle_cycles;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t ns: no word moved for %0d cycles", $time, STALL_LIMIT);
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles++;
      end
   end

   initial begin
      logic [3:0] mid_offset;
      for (int i = 0; i < STORE_BYTES; i++) begin
         frame_copy[i] = 8'h00;
         backup_copy[i] = 8'h00;
      end
      mid_offset = 4'($urandom_range(1, 14));
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // The opening phase runs with the column offset left at its reset value.
      queue_op(REQ_TICK);
      queue_request(REQ_DRAW, 8'd0, 8'd0, 1'b1);
      queue_request(REQ_DRAW, 8'd127, 8'd63, 1'b1);
      queue_request(REQ_DRAW, 8'd128, 8'd0, 1'b1);
      queue_request(REQ_DRAW, 8'd0, 8'd64, 1'b1);
      queue_request(REQ_DRAW, 8'd255, 8'd255, 1'b1);
      queue_request(REQ_DRAW, 8'd2, 8'd7, 1'b1);
      queue_request(REQ_DRAW, 8'd2, 8'd7, 1'b0);
      queue_request(REQ_DRAW, 8'd1, 8'd0, 1'b1);
      queue_op(REQ_SPARE_SIX);
      queue_op(REQ_SPARE_SEVEN);
      queue_op(REQ_SAVE);
      queue_op(REQ_CLEAR);
      queue_op(REQ_RESTORE);
      queue_op(REQ_START);
      repeat (4) queue_op(REQ_TICK);
      queue_request(REQ_DRAW, 8'd1, 8'd1, 1'b1);
      queue_op(REQ_TICK);
      queue_op(REQ_START);
      repeat (3) queue_op(REQ_TICK);

      set_column_offset(4'hF);
      repeat (60) queue_random_draw();
      queue_refresh(40, 5);
      queue_random_phase(RANDOM_REQUESTS / 5);

      set_column_offset(4'h0);
      queue_random_phase(RANDOM_REQUESTS / 4);

      set_column_offset(mid_offset);
      queue_random_phase(RANDOM_REQUESTS / 5);
      queue_op(REQ_TICK);

      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d request words, %0d of them store sweeps,", requests_taken,
               sweeps_queued);
      $display("at column offsets 2, 15, 0, %0d; checked %0d panel words, %0d frames.",
               mid_offset, panel_words_checked, frames_finished);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
